// ===== rtl/core/pva_pkg.sv =====
// pva_pkg: shared types and constants of the polyphonic voice allocator
// no dependencies; used by the sequencer and the top level
`default_nettype none

package pva_pkg;

    // configuration port
    localparam int CFG_DATA_W = 4;
    localparam logic CFG_IDX_MAX_VOICES  = 1'b0;
    localparam logic CFG_IDX_ROUND_ROBIN = 1'b1;

    // input command codes
    localparam logic CMD_NOTE  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] max_voices;
        logic                  round_robin;
    } cfg_t;

    // control of one result transaction from the sequencer
    typedef struct packed {
        logic valid;
        logic flush_mark;
        logic last;
    } push_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SEARCH,
        ST_ONPUT,
        ST_FLUSH,
        ST_MATCH,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/pva_pitch_ram.sv =====
// pva_pitch_ram: per-voice pitch store, one write port and one registered read port
// no dependencies
`default_nettype none

module pva_pitch_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 16,
    parameter int AW    = 3
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/pva_seq.sv =====
// pva_seq: sequencer of the voice allocator; active bits, pointer, active count,
// one-voice-per-cycle search and pitch compare. depends on pva_pkg, pva_pitch_ram
`default_nettype none

module pva_seq #(
    parameter int VOICES    = 8,
    parameter int CODE_BITS = 16,
    parameter int IDX_W     = (VOICES > 1) ? $clog2(VOICES) : 1,
    parameter int CNT_W     = $clog2(VOICES + 1)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire pva_pkg::cfg_t        cfg_i,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 in_cmd,
    input  wire logic [CODE_BITS-1:0] in_pitch,
    input  wire logic [CODE_BITS-1:0] in_velocity,
    input  wire logic                 out_free,
    output pva_pkg::push_t            push,
    output logic      [IDX_W-1:0]     res_voice,
    output logic      [CODE_BITS-1:0] res_pitch,
    output logic      [CODE_BITS-1:0] res_velocity,
    output logic      [CNT_W-1:0]     res_count
);

    pva_pkg::state_t state_reg, state_next;

    logic [CODE_BITS-1:0] pitch_reg, pitch_next;
    logic [CODE_BITS-1:0] vel_reg, vel_next;
    logic [VOICES-1:0]    active_reg, active_next;
    logic [VOICES-1:0]    mask_reg, mask_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     rr_reg, rr_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]     sel_reg, sel_next;

    logic [CNT_W-1:0]     n_use;
    logic [CNT_W-1:0]     n_minus1;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_raddr;
    logic [CODE_BITS-1:0] ram_rdata;
    logic                 hit;
    logic [VOICES-1:0]    idx_bit;
    logic [IDX_W-1:0]     idx_wrap;
    logic [IDX_W-1:0]     sel_wrap;

    // voices in use, clamped to 1..VOICES
    always_comb begin
        if (cfg_i.max_voices == '0) begin
            n_use = CNT_W'(1);
        end else if (32'(cfg_i.max_voices) > VOICES) begin
            n_use = CNT_W'(VOICES);
        end else begin
            n_use = CNT_W'(cfg_i.max_voices);
        end
    end

    assign n_minus1 = n_use - CNT_W'(1);
    assign idx_wrap = (CNT_W'(idx_reg) + CNT_W'(1) == n_use) ? '0 : idx_reg + IDX_W'(1);
    assign sel_wrap = (CNT_W'(sel_reg) + CNT_W'(1) == n_use) ? '0 : sel_reg + IDX_W'(1);
    assign idx_bit  = VOICES'(1) << idx_reg;
    assign hit      = cmp_valid_reg && active_reg[cmp_idx_reg] && (ram_rdata == pitch_reg);
    assign ram_raddr = (32'(scan_reg) < VOICES) ? scan_reg[IDX_W-1:0] : '0;
    assign ram_we   = (state_reg == pva_pkg::ST_ONPUT) && out_free;

    pva_pitch_ram #(
        .DEPTH (VOICES),
        .WIDTH (CODE_BITS),
        .AW    (IDX_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (sel_reg),
        .wdata (pitch_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pva_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (in_cmd == pva_pkg::CMD_FLUSH) begin
                        state_next = pva_pkg::ST_FLUSH;
                    end else if (in_velocity == '0) begin
                        state_next = pva_pkg::ST_MATCH;
                    end else if (cfg_i.round_robin) begin
                        state_next = pva_pkg::ST_MOD;
                    end else begin
                        state_next = pva_pkg::ST_SEARCH;
                    end
                end
            end
            pva_pkg::ST_MOD: begin
                if (ptr_reg < n_use) begin
                    state_next = pva_pkg::ST_SEARCH;
                end
            end
            pva_pkg::ST_SEARCH: begin
                if (!active_reg[idx_reg] || scan_reg == n_minus1) begin
                    state_next = pva_pkg::ST_ONPUT;
                end
            end
            pva_pkg::ST_ONPUT: begin
                if (out_free) begin
                    state_next = pva_pkg::ST_IDLE;
                end
            end
            pva_pkg::ST_FLUSH: begin
                if (out_free && idx_reg == IDX_W'(VOICES - 1)) begin
                    state_next = pva_pkg::ST_IDLE;
                end
            end
            pva_pkg::ST_MATCH: begin
                if (32'(scan_reg) == VOICES && !cmp_valid_reg) begin
                    state_next = pva_pkg::ST_EMIT;
                end
            end
            pva_pkg::ST_EMIT: begin
                if (mask_reg == '0) begin
                    state_next = pva_pkg::ST_IDLE;
                end
            end
            default: state_next = pva_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        pitch_next     = pitch_reg;
        vel_next       = vel_reg;
        active_next    = active_reg;
        mask_next      = mask_reg;
        count_next     = count_reg;
        rr_next        = rr_reg;
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        scan_next      = scan_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        sel_next       = sel_reg;
        in_ready       = 1'b0;
        push           = '0;
        res_voice      = idx_reg;
        res_pitch      = pitch_reg;
        res_velocity   = '0;
        res_count      = count_reg;

        case (state_reg)
            pva_pkg::ST_IDLE: begin
                in_ready   = 1'b1;
                pitch_next = in_pitch;
                vel_next   = in_velocity;
                ptr_next   = CNT_W'(rr_reg);
                idx_next   = '0;
                scan_next  = '0;
                mask_next  = '0;
                if (in_valid && in_cmd == pva_pkg::CMD_FLUSH) begin
                    active_next = '0;
                    count_next  = '0;
                end
            end
            pva_pkg::ST_MOD: begin
                // pointer modulo voices in use, one subtract per cycle
                if (ptr_reg >= n_use) begin
                    ptr_next = ptr_reg - n_use;
                end else begin
                    idx_next  = ptr_reg[IDX_W-1:0];
                    scan_next = '0;
                end
            end
            pva_pkg::ST_SEARCH: begin
                if (!active_reg[idx_reg]) begin
                    sel_next = idx_reg;
                end else if (scan_reg == n_minus1) begin
                    sel_next = cfg_i.round_robin ? ptr_reg[IDX_W-1:0] : n_minus1[IDX_W-1:0];
                end else begin
                    idx_next  = idx_wrap;
                    scan_next = scan_reg + CNT_W'(1);
                end
            end
            pva_pkg::ST_ONPUT: begin
                res_voice    = sel_reg;
                res_velocity = vel_reg;
                res_count    = count_reg + CNT_W'(!active_reg[sel_reg]);
                if (out_free) begin
                    push.valid           = 1'b1;
                    push.last            = 1'b1;
                    active_next[sel_reg] = 1'b1;
                    count_next           = res_count;
                    if (cfg_i.round_robin) begin
                        rr_next = sel_wrap;
                    end
                end
            end
            pva_pkg::ST_FLUSH: begin
                res_pitch = '0;
                if (out_free) begin
                    push.valid      = 1'b1;
                    push.flush_mark = 1'b1;
                    push.last       = (idx_reg == IDX_W'(VOICES - 1));
                    idx_next        = idx_reg + IDX_W'(1);
                end
            end
            pva_pkg::ST_MATCH: begin
                // read one voice per cycle, compare on the following cycle
                if (32'(scan_reg) < VOICES) begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg[IDX_W-1:0];
                    scan_next      = scan_reg + CNT_W'(1);
                end
                if (hit) begin
                    mask_next[cmp_idx_reg]   = 1'b1;
                    active_next[cmp_idx_reg] = 1'b0;
                    count_next               = count_reg - CNT_W'(1);
                end
            end
            pva_pkg::ST_EMIT: begin
                if (mask_reg != '0) begin
                    if (mask_reg[idx_reg]) begin
                        if (out_free) begin
                            push.valid = 1'b1;
                            push.last  = ((mask_reg & ~idx_bit) == '0);
                            mask_next  = mask_reg & ~idx_bit;
                            idx_next   = idx_reg + IDX_W'(1);
                        end
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pva_pkg::ST_IDLE;
            active_reg    <= '0;
            count_reg     <= '0;
            rr_reg        <= '0;
            cmp_valid_reg <= 1'b0;
            mask_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            count_reg     <= count_next;
            rr_reg        <= rr_next;
            cmp_valid_reg <= cmp_valid_next;
            mask_reg      <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        pitch_reg   <= pitch_next;
        vel_reg     <= vel_next;
        ptr_reg     <= ptr_next;
        idx_reg     <= idx_next;
        scan_reg    <= scan_next;
        cmp_idx_reg <= cmp_idx_next;
        sel_reg     <= sel_next;
    end

    // active count tracks the active bits
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) == $countones(active_reg))
        else $error("active count out of step with active bits");

    a_push_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> out_free)
        else $error("result pushed into a full output register");

    a_rr_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_i.round_robin |=> $stable(rr_reg))
        else $error("pointer moved in lowest-free mode");

    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.valid && push.flush_mark && push.last) |-> (res_voice == IDX_W'(VOICES - 1)))
        else $error("flush ended before the top voice");

endmodule

`default_nettype wire

// ===== rtl/core/poly_voice_allocator_core.sv =====
// poly_voice_allocator_core: top level of the polyphonic voice allocator
// depends on pva_pkg, pva_seq (which holds pva_pitch_ram)
//
// Input channel (s_*): one note event or flush per transaction. Velocity zero
// is a note off. A note on gives one result, a note off one result per
// released voice (possibly none), a flush one result per voice.
// Result channel (m_*): valid/ready; m_last marks the final result of an input.
// Config: cfg_wr_en writes cfg_wdata to register cfg_addr (0 max_voices,
// 1 round_robin_mode); write only while the block is idle.
// Steps to the last result, with n the voices in use and no back-pressure:
//   note on, lowest-free mode: search of the voices (one voice tested per cycle)
//   note on, round-robin: the pointer is reduced mod n by subtraction before the search
//   note off: all pitches compared (one pitch read per cycle, then one
//   voice per cycle through the release mask)
//   flush: every voice in turn (one result per cycle)
// s_ready is high only while the sequencer is idle. A registered output stage
// holds each result; when m_ready stays low the sequencer waits before pushing another.
// Reset clears all voices, the pointer and the active count, and sets
// max_voices to 8 and round-robin mode on. No clearing pass is needed.
`default_nettype none

module poly_voice_allocator_core #(
    parameter int VOICES    = 8,
    parameter int CODE_BITS = 16,
    parameter int IDX_W     = (VOICES > 1) ? $clog2(VOICES) : 1,
    parameter int CNT_W     = $clog2(VOICES + 1)
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic                           cfg_addr,
    input  wire logic [pva_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_cmd,
    input  wire logic [CODE_BITS-1:0]           s_note_pitch,
    input  wire logic [CODE_BITS-1:0]           s_note_velocity,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [IDX_W-1:0]               m_voice_index,
    output logic      [CODE_BITS-1:0]           m_out_pitch,
    output logic      [CODE_BITS-1:0]           m_out_velocity,
    output logic                                m_flush_mark,
    output logic      [CNT_W-1:0]               m_active_count,
    output logic                                m_last
);

    pva_pkg::cfg_t  cfg_reg;
    pva_pkg::push_t push;

    logic                 out_free;
    logic                 m_valid_reg;
    logic [IDX_W-1:0]     res_voice;
    logic [CODE_BITS-1:0] res_pitch;
    logic [CODE_BITS-1:0] res_velocity;
    logic [CNT_W-1:0]     res_count;
    logic [IDX_W-1:0]     voice_reg;
    logic [CODE_BITS-1:0] pitch_reg;
    logic [CODE_BITS-1:0] velocity_reg;
    logic                 flush_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_voices  <= pva_pkg::CFG_DATA_W'(8);
            cfg_reg.round_robin <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                pva_pkg::CFG_IDX_MAX_VOICES:  cfg_reg.max_voices  <= cfg_wdata;
                pva_pkg::CFG_IDX_ROUND_ROBIN: cfg_reg.round_robin <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    pva_seq #(
        .VOICES    (VOICES),
        .CODE_BITS (CODE_BITS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_i        (cfg_reg),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_cmd       (s_cmd),
        .in_pitch     (s_note_pitch),
        .in_velocity  (s_note_velocity),
        .out_free     (out_free),
        .push         (push),
        .res_voice    (res_voice),
        .res_pitch    (res_pitch),
        .res_velocity (res_velocity),
        .res_count    (res_count)
    );

    // output register stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            voice_reg    <= res_voice;
            pitch_reg    <= res_pitch;
            velocity_reg <= res_velocity;
            flush_reg    <= push.flush_mark;
            count_reg    <= res_count;
            last_reg     <= push.last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_voice_index  = voice_reg;
    assign m_out_pitch    = pitch_reg;
    assign m_out_velocity = velocity_reg;
    assign m_flush_mark   = flush_reg;
    assign m_active_count = count_reg;
    assign m_last         = last_reg;

endmodule

`default_nettype wire
